// ===== design/rc5d_pkg.sv =====
// Shared types and constants for the RC5 infrared frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package rc5d_pkg;

  // Capture timer width and frame geometry.
  localparam int STAMP_BITS    = 16;
  localparam int FRAME_LENGTH  = 14;
  localparam int TOTAL_BITS    = $clog2(FRAME_LENGTH + 1);
  localparam int START_BITS    = 2;
  localparam int START_PATTERN = 3;
  localparam int CFG_BITS      = 16;
  localparam int CFG_IDX_BITS  = 3;

  // Field positions inside a received frame.
  localparam int CMD_BITS    = 6;
  localparam int ADDR_BITS   = 5;
  localparam int CMD_LSB     = 0;
  localparam int ADDR_LSB    = CMD_LSB + CMD_BITS;
  localparam int TOGGLE_POS  = ADDR_LSB + ADDR_BITS;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_MIN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_MAX = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_MIN  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_MAX  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_MIN   = 3'd4;

  // Threshold reset values in timer ticks.
  localparam logic [CFG_BITS-1:0] RST_SHORT_MIN = 16'd444;
  localparam logic [CFG_BITS-1:0] RST_SHORT_MAX = 16'd1333;
  localparam logic [CFG_BITS-1:0] RST_LONG_MIN  = 16'd1334;
  localparam logic [CFG_BITS-1:0] RST_LONG_MAX  = 16'd2222;
  localparam logic [CFG_BITS-1:0] RST_GAP_MIN   = 16'd5000;

  // Pulse symbols: short or long, with the pin level after the edge.
  typedef enum logic [2:0] {
    SYM_SL,
    SYM_SH,
    SYM_LL,
    SYM_LH,
    SYM_BAD
  } sym_t;

  // Threshold register set.
  typedef struct packed {
    logic [CFG_BITS-1:0] short_min;
    logic [CFG_BITS-1:0] short_max;
    logic [CFG_BITS-1:0] long_min;
    logic [CFG_BITS-1:0] long_max;
    logic [CFG_BITS-1:0] gap_min;
  } cfg_t;

  // Classification of one edge.
  typedef struct packed {
    sym_t sym;
    logic rearm;
  } cls_t;

  // Frame produced by one edge, if any.
  typedef struct packed {
    logic                    valid;
    logic [FRAME_LENGTH-1:0] bits;
  } frame_t;

endpackage

`default_nettype wire

// ===== design/rc5d_cfg_regs.sv =====
// Threshold configuration registers of the RC5 decoder.
`timescale 1ns / 1ps
`default_nettype none

module rc5d_cfg_regs
  import rc5d_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_wdata,
  output cfg_t                         cfg
);

  cfg_t cfg_r;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_min <= RST_SHORT_MIN;
      cfg_r.short_max <= RST_SHORT_MAX;
      cfg_r.long_min  <= RST_LONG_MIN;
      cfg_r.long_max  <= RST_LONG_MAX;
      cfg_r.gap_min   <= RST_GAP_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHORT_MIN: cfg_r.short_min <= cfg_wdata;
        CFG_SHORT_MAX: cfg_r.short_max <= cfg_wdata;
        CFG_LONG_MIN:  cfg_r.long_min  <= cfg_wdata;
        CFG_LONG_MAX:  cfg_r.long_max  <= cfg_wdata;
        CFG_GAP_MIN:   cfg_r.gap_min   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== design/rc5d_classify.sv =====
// Pulse length measurement and short/long classification of each edge.
`timescale 1ns / 1ps
`default_nettype none

module rc5d_classify
  import rc5d_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  fire,
  input  wire logic [STAMP_BITS-1:0] stamp,
  input  wire logic                  pin,
  input  cfg_t                       cfg,
  output cls_t                       cls
);

  logic [STAMP_BITS-1:0] prev_stamp_r;
  logic                  first_edge_r;
  logic [STAMP_BITS-1:0] pulse_len;
  logic                  is_short;
  logic                  is_long;
  logic                  gap;

  // Previous timestamp; the first edge after reset counts as a huge pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_stamp_r <= '0;
      first_edge_r <= 1'b1;
    end else if (fire) begin
      prev_stamp_r <= stamp;
      first_edge_r <= 1'b0;
    end
  end

  // Length wraps modulo the timer range; thresholds are zero-extended.
  always_comb begin
    pulse_len = stamp - prev_stamp_r;
    is_short  = !first_edge_r
                && (32'(pulse_len) >= 32'(cfg.short_min))
                && (32'(pulse_len) <= 32'(cfg.short_max));
    is_long   = !first_edge_r && !is_short
                && (32'(pulse_len) >= 32'(cfg.long_min))
                && (32'(pulse_len) <= 32'(cfg.long_max));
    gap       = first_edge_r || (32'(pulse_len) > 32'(cfg.gap_min));

    if (is_short) begin
      cls.sym = pin ? SYM_SH : SYM_SL;
    end else if (is_long) begin
      cls.sym = pin ? SYM_LH : SYM_LL;
    end else begin
      cls.sym = SYM_BAD;
    end
    cls.rearm = gap && !pin;
  end

endmodule

`default_nettype wire

// ===== design/rc5d_fsm.sv =====
// Manchester bit decoder: phase, bit shifter and frame completion.
`timescale 1ns / 1ps
`default_nettype none

module rc5d_fsm
  import rc5d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic fire,
  input  cls_t      cls,
  output frame_t    frame
);

  typedef enum logic [2:0] {
    PH_MID0,
    PH_MID1,
    PH_START0,
    PH_START1,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    phase_t                  phase;
    logic [FRAME_LENGTH-1:0] bits;
    logic [TOTAL_BITS-1:0]   total;
    logic                    done;
    logic [FRAME_LENGTH-1:0] frame;
  } step_t;

  phase_t                  phase_r;
  logic [FRAME_LENGTH-1:0] bits_r;
  logic [TOTAL_BITS-1:0]   total_r;
  logic                    armed_r;

  step_t st0;
  step_t st1;
  step_t st2;
  logic  armed_nxt;

  // One symbol applied to the decoder state.
  function automatic step_t machine_step(step_t st, sym_t s);
    step_t r;
    r       = st;
    r.done  = 1'b0;
    r.frame = '0;
    unique case (st.phase)
      PH_MID0: begin
        r.bits  = {st.bits[FRAME_LENGTH-2:0], 1'b0};
        r.total = st.total + TOTAL_BITS'(1);
        r.phase = (s == SYM_LL) ? PH_MID1 : (s == SYM_SL) ? PH_START0 : PH_IDLE;
      end
      PH_MID1: begin
        r.bits  = {st.bits[FRAME_LENGTH-2:0], 1'b1};
        r.total = st.total + TOTAL_BITS'(1);
        if (r.total == TOTAL_BITS'(START_BITS)
            && r.bits != FRAME_LENGTH'(START_PATTERN)) begin
          r.phase = PH_IDLE;
        end else begin
          r.phase = (s == SYM_LH) ? PH_MID0 : (s == SYM_SH) ? PH_START1 : PH_IDLE;
        end
      end
      PH_START0: r.phase = (s == SYM_SH) ? PH_MID0 : PH_IDLE;
      PH_START1: r.phase = (s == SYM_SL) ? PH_MID1 : PH_IDLE;
      default: begin
        r.bits  = '0;
        r.total = '0;
        r.phase = (s == SYM_SL) ? PH_MID1 : PH_IDLE;
      end
    endcase
    // A full frame is handed out and the decoder starts over.
    if (r.total == TOTAL_BITS'(FRAME_LENGTH)) begin
      r.frame = r.bits;
      r.done  = 1'b1;
      r.bits  = '0;
      r.total = '0;
      r.phase = PH_IDLE;
    end
    return r;
  endfunction

  // The edge symbol runs first when armed; a gap with a low pin then re-arms
  // and applies a short-low symbol on top.
  always_comb begin
    st0       = '{phase: phase_r, bits: bits_r, total: total_r,
                  done: 1'b0, frame: '0};
    st1       = armed_r ? machine_step(st0, cls.sym) : st0;
    armed_nxt = armed_r && !st1.done;
    st2       = st1;
    st2.done  = 1'b0;
    if (cls.rearm) begin
      armed_nxt = 1'b1;
      st2       = machine_step(st1, SYM_SL);
    end
    frame.valid = st1.done || st2.done;
    frame.bits  = st2.done ? st2.frame : st1.frame;
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bits_r  <= '0;
      total_r <= '0;
      armed_r <= 1'b0;
    end else if (fire) begin
      phase_r <= st2.phase;
      bits_r  <= st2.bits;
      total_r <= st2.total;
      armed_r <= armed_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/rc5_ir_frame_decoder_unit.sv =====
// Top level of the RC5 infrared frame decoder.
// An accepted edge item is held in the input register, classified and decoded
// between the input and result registers, and its frame, if any, is registered
// in the result register. Throughput: one edge item per cycle unless out_stall holds a result.
// Reset: synchronous, active low; clears the decoder, the pipeline and
// restores the threshold registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module rc5_ir_frame_decoder_unit
  import rc5d_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [STAMP_BITS-1:0]   in_edge_stamp,
  input  wire logic                    in_pin_level,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [ADDR_BITS-1:0]         out_device_address,
  output logic                         out_toggle_bit,
  output logic [CMD_BITS-1:0]          out_command_code,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_wdata
);

  logic                    s1_valid_r;
  logic [STAMP_BITS-1:0]   s1_stamp_r;
  logic                    s1_pin_r;
  logic                    out_valid_r;
  logic [FRAME_LENGTH-1:0] out_frame_r;

  logic   can_proc;
  logic   fire;
  logic   advance;
  cfg_t   cfg;
  cls_t   cls;
  frame_t frame;

  // The held item is processed once the result register can take a result.
  assign can_proc = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && can_proc;
  assign advance  = !s1_valid_r || can_proc;
  assign in_stall = !advance;

  rc5d_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rc5d_classify u_classify (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .stamp (s1_stamp_r),
    .pin   (s1_pin_r),
    .cfg   (cfg),
    .cls   (cls)
  );

  rc5d_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .cls   (cls),
    .frame (frame)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      s1_stamp_r <= in_edge_stamp;
      s1_pin_r   <= in_pin_level;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_proc) begin
      out_valid_r <= fire && frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && frame.valid) begin
      out_frame_r <= frame.bits;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_device_address = out_frame_r[ADDR_LSB +: ADDR_BITS];
  assign out_toggle_bit     = out_frame_r[TOGGLE_POS];
  assign out_command_code   = out_frame_r[CMD_LSB +: CMD_BITS];

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the RC5 infrared frame decoder unit.
`timescale 1ns / 1ps

module tb_top;
  import rc5d_pkg::*;

  // Decoder phases as the predictor tracks them.
  typedef enum logic [2:0] {
    DP_MID_LOW    = 3'd0,
    DP_MID_HIGH   = 3'd1,
    DP_START_LOW  = 3'd2,
    DP_START_HIGH = 3'd3,
    DP_IDLE       = 3'd4
  } dec_phase_t;

  // One decoded command as it leaves the block.
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic                 toggle;
    logic [CMD_BITS-1:0]  cmd;
  } rc5_cmd_t;

  // Predicts decoded commands from accepted edges and checks the block's results.
  class rc5_frame_scoreboard;
    cfg_t                    thr;
    dec_phase_t              phase;
    logic [FRAME_LENGTH-1:0] bits;
    logic [3:0]              count;
    bit                      armed;
    logic [STAMP_BITS-1:0]   prev_stamp;
    bit                      first_edge;
    logic [FRAME_LENGTH-1:0] done_frame;
    rc5_cmd_t                expected_cmds[$];
    int                      errors;

    function new();
      thr.short_min = RST_SHORT_MIN;
      thr.short_max = RST_SHORT_MAX;
      thr.long_min  = RST_LONG_MIN;
      thr.long_max  = RST_LONG_MAX;
      thr.gap_min   = RST_GAP_MIN;
      phase      = DP_IDLE;
      bits       = '0;
      count      = '0;
      armed      = 1'b0;
      prev_stamp = '0;
      first_edge = 1'b1;
      errors     = 0;
    endfunction

    // Only the first ten failures are printed; all of them are counted.
    function void report(string msg);
      if (errors < 10) $display("[%0t] ERROR: %s", $realtime, msg);
      errors++;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      case (idx)
        CFG_SHORT_MIN: thr.short_min = val;
        CFG_SHORT_MAX: thr.short_max = val;
        CFG_LONG_MIN:  thr.long_min  = val;
        CFG_LONG_MAX:  thr.long_max  = val;
        CFG_GAP_MIN:   thr.gap_min   = val;
        default: ;
      endcase
    endfunction

    // Manchester state machine; returns 1 when the last frame bit was shifted in.
    function bit advance(sym_t s);
      case (phase)
        DP_MID_LOW: begin
          bits  = {bits[FRAME_LENGTH-2:0], 1'b0};
          count = count + 4'd1;
          phase = (s == SYM_LL) ? DP_MID_HIGH : (s == SYM_SL) ? DP_START_LOW : DP_IDLE;
        end
        DP_MID_HIGH: begin
          bits  = {bits[FRAME_LENGTH-2:0], 1'b1};
          count = count + 4'd1;
          // The second shifted bit must complete a pair of start ones.
          if (count == START_BITS && bits != START_PATTERN)
            phase = DP_IDLE;
          else
            phase = (s == SYM_LH) ? DP_MID_LOW : (s == SYM_SH) ? DP_START_HIGH : DP_IDLE;
        end
        DP_START_LOW:  phase = (s == SYM_SH) ? DP_MID_LOW : DP_IDLE;
        DP_START_HIGH: phase = (s == SYM_SL) ? DP_MID_HIGH : DP_IDLE;
        default: begin
          bits  = '0;
          count = '0;
          phase = (s == SYM_SL) ? DP_MID_HIGH : DP_IDLE;
        end
      endcase
      if (count == FRAME_LENGTH) begin
        done_frame = bits;
        bits       = '0;
        count      = '0;
        phase      = DP_IDLE;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Classify the pulse ending at this edge and run it through the decoder.
    function void note_edge(logic [STAMP_BITS-1:0] stamp, logic pin);
      logic [STAMP_BITS-1:0] len;
      bit                    is_short;
      bit                    is_long;
      bit                    gap;
      bit                    got;
      sym_t                  s;
      rc5_cmd_t              c;
      len      = stamp - prev_stamp;
      is_short = !first_edge && len >= thr.short_min && len <= thr.short_max;
      is_long  = !first_edge && !is_short && len >= thr.long_min && len <= thr.long_max;
      gap      = first_edge || len > thr.gap_min;
      if (is_short)
        s = pin ? SYM_SH : SYM_SL;
      else if (is_long)
        s = pin ? SYM_LH : SYM_LL;
      else
        s = SYM_BAD;
      got = 1'b0;
      if (armed && advance(s)) begin
        got   = 1'b1;
        armed = 1'b0;
      end
      // A long pause ending low starts a new frame on the same edge.
      if (gap && !pin) begin
        armed = 1'b1;
        if (advance(SYM_SL)) got = 1'b1;
      end
      prev_stamp = stamp;
      first_edge = 1'b0;
      if (got) begin
        c.addr   = done_frame[ADDR_LSB +: ADDR_BITS];
        c.toggle = done_frame[TOGGLE_POS];
        c.cmd    = done_frame[CMD_LSB +: CMD_BITS];
        expected_cmds.push_back(c);
      end
    endfunction

    function void check_frame(logic [ADDR_BITS-1:0] addr, logic toggle,
                              logic [CMD_BITS-1:0] cmd);
      rc5_cmd_t c;
      if (expected_cmds.size() == 0) begin
        report($sformatf("unexpected result addr=%0d toggle=%0d cmd=%0d",
                         addr, toggle, cmd));
        return;
      end
      c = expected_cmds.pop_front();
      if (addr !== c.addr || toggle !== c.toggle || cmd !== c.cmd)
        report($sformatf({"expected addr=%0d toggle=%0d cmd=%0d, ",
                          "got addr=%0d toggle=%0d cmd=%0d"},
                         c.addr, c.toggle, c.cmd, addr, toggle, cmd));
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [STAMP_BITS-1:0]   in_edge_stamp = '0;
  logic                    in_pin_level = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ADDR_BITS-1:0]    out_device_address;
  logic                    out_toggle_bit;
  logic [CMD_BITS-1:0]     out_command_code;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_wdata = '0;

  rc5_frame_scoreboard sb = new();

  // Stimulus bookkeeping: the running timer, the line level and the active thresholds.
  logic [STAMP_BITS-1:0] stamp_now = '0;
  logic                  line_level = 1'b1;
  cfg_t                  live_thr;
  int                    sent_count = 0;
  bit                    in_idle_on = 1'b1;
  bit                    out_idle_on = 1'b1;
  int                    long_hold = 0;

  rc5_ir_frame_decoder_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_edge_stamp      (in_edge_stamp),
    .in_pin_level       (in_pin_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_device_address (out_device_address),
    .out_toggle_bit     (out_toggle_bit),
    .out_command_code   (out_command_code),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watch both channels and the register port at every clock edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we === 1'b1) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_stall === 1'b0) sb.note_edge(in_edge_stamp, in_pin_level);
      if (out_valid === 1'b1 && !out_stall)
        sb.check_frame(out_device_address, out_toggle_bit, out_command_code);
    end
  end

  // Result side: a random hold-off before each item, or a long one on request.
  initial begin
    int n;
    forever begin
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
      end else begin
        n = out_idle_on ? $urandom_range(0, 12) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [STAMP_BITS-1:0] pick_short();
    return STAMP_BITS'($urandom_range(live_thr.short_min, live_thr.short_max));
  endfunction

  function automatic logic [STAMP_BITS-1:0] pick_long();
    return STAMP_BITS'($urandom_range(live_thr.long_min, live_thr.long_max));
  endfunction

  // A pause that exceeds gap_min, or any length when no pause can exceed it.
  function automatic logic [STAMP_BITS-1:0] pick_gap();
    int lo;
    int hi;
    if (live_thr.gap_min == 16'hFFFF) return STAMP_BITS'($urandom_range(0, 65535));
    lo = live_thr.gap_min + 1;
    hi = (lo + 8000 > 65535) ? 65535 : lo + 8000;
    return STAMP_BITS'($urandom_range(lo, hi));
  endfunction

  // Offer one edge item a pulse length after the previous one.
  task automatic send_edge(input logic [STAMP_BITS-1:0] len, input logic pin);
    int wait_n;
    wait_n = in_idle_on ? $urandom_range(0, 12) : 0;
    stamp_now = stamp_now + len;
    if (wait_n > 0) begin
      in_valid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_edge_stamp <= stamp_now;
    in_pin_level  <= pin;
    do @(posedge clk); while (in_stall !== 1'b0);
    line_level = pin;
    sent_count++;
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_edge(STAMP_BITS'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  // Send a frame as the edges of its Manchester waveform; a broken frame gets
  // at most one pulse of random length.
  task automatic send_frame(input logic [FRAME_LENGTH-1:0] fbits, input bit broken);
    logic [2*FRAME_LENGTH-1:0] lv;
    logic                      prev;
    logic [STAMP_BITS-1:0]     len;
    int                        k;
    int                        last;
    int                        edge_no;
    int                        bad_no;
    // A one is high then low on the inverted line, a zero low then high.
    for (k = 0; k < FRAME_LENGTH; k++) begin
      lv[2*k]   = fbits[FRAME_LENGTH-1-k];
      lv[2*k+1] = ~fbits[FRAME_LENGTH-1-k];
    end
    if (line_level == 1'b0) send_edge(pick_short(), 1'b1);
    bad_no  = broken ? int'($urandom_range(0, 20)) : -1;
    prev    = 1'b1;
    last    = 0;
    edge_no = 0;
    for (k = 0; k < 2*FRAME_LENGTH; k++) begin
      if (lv[k] != prev) begin
        if (edge_no == 0)
          len = pick_gap();
        else if (k - last == 1)
          len = pick_short();
        else
          len = pick_long();
        if (edge_no == bad_no) len = STAMP_BITS'($urandom_range(0, 65535));
        send_edge(len, lv[k]);
        prev = lv[k];
        last = k;
        edge_no++;
      end
    end
    // Return to the idle level after a trailing one.
    if (prev == 1'b0) send_edge(pick_short(), 1'b1);
  endtask

  // Mostly proper start bits; now and then arbitrary ones.
  function automatic logic [FRAME_LENGTH-1:0] make_bits();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 7) == 0) return r[FRAME_LENGTH-1:0];
    return {2'b11, r[FRAME_LENGTH-3:0]};
  endfunction

  // Let the block drain completely before touching its registers.
  task automatic wait_quiet();
    int k;
    in_valid <= 1'b0;
    for (k = 0; k < 5000 && sb.pending() != 0; k++) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic write_thresholds(input logic [CFG_BITS-1:0] smin,
                                  input logic [CFG_BITS-1:0] smax,
                                  input logic [CFG_BITS-1:0] lmin,
                                  input logic [CFG_BITS-1:0] lmax,
                                  input logic [CFG_BITS-1:0] gmin);
    wait_quiet();
    put_reg(CFG_SHORT_MIN, smin);
    put_reg(CFG_SHORT_MAX, smax);
    put_reg(CFG_LONG_MIN, lmin);
    put_reg(CFG_LONG_MAX, lmax);
    put_reg(CFG_GAP_MIN, gmin);
    cfg_we <= 1'b0;
    live_thr.short_min = smin;
    live_thr.short_max = smax;
    live_thr.long_min  = lmin;
    live_thr.long_max  = lmax;
    live_thr.gap_min   = gmin;
  endtask

  // Random traffic: mostly clean frames, some broken frames and bursts of noise.
  task automatic run_traffic(input int budget);
    int stop_at;
    int pick;
    stop_at = sent_count + budget;
    while (sent_count < stop_at) begin
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0)
        send_noise($urandom_range(1, 4));
      else
        send_frame(make_bits(), pick == 1);
    end
  endtask

  initial begin
    int h;
    int k;
    live_thr.short_min = RST_SHORT_MIN;
    live_thr.short_max = RST_SHORT_MAX;
    live_thr.long_min  = RST_LONG_MIN;
    live_thr.long_max  = RST_LONG_MAX;
    live_thr.gap_min   = RST_GAP_MIN;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first edge after reset, a wrapping stamp, a clean frame that
    // the next pause completes, then an out-of-range pulse in an armed decoder.
    send_edge(16'hFFFF, 1'b1);
    send_edge(16'd1, 1'b0);
    send_frame(14'b11_0_10101_010100, 1'b0);
    send_edge(pick_gap(), 1'b0);
    send_edge(16'd3, 1'b1);

    run_traffic(200);

    // Fast timing, with a long result hold-off while edges keep coming.
    write_thresholds(16'd100, 16'd300, 16'd301, 16'd600, 16'd1500);
    in_idle_on  = 1'b0;
    long_hold   = 400;
    for (k = 0; k < 8; k++) send_frame(make_bits(), 1'b0);
    run_traffic(200);

    // Extremes: everything short and no pause ever long enough.
    write_thresholds(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    run_traffic(60);

    // Extremes: zero-width windows and any nonzero pause counts as a gap.
    write_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_traffic(80);

    // Overlapping short and long windows.
    write_thresholds(16'd400, 16'd1500, 16'd1200, 16'd2400, 16'd6000);
    run_traffic(200);

    // Timing scaled from a random half-bit length.
    h = $urandom_range(60, 3000);
    write_thresholds(CFG_BITS'(h - h / 3), CFG_BITS'(h + h / 3),
                     CFG_BITS'(h + h / 3 + 1), CFG_BITS'(2 * h + 2 * h / 3),
                     CFG_BITS'(5 * h));
    run_traffic(200);

    // Defaults written back explicitly.
    write_thresholds(RST_SHORT_MIN, RST_SHORT_MAX, RST_LONG_MIN, RST_LONG_MAX, RST_GAP_MIN);
    run_traffic(200);

    wait_quiet();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
design/rc5d_pkg.sv
design/rc5d_cfg_regs.sv
design/rc5d_classify.sv
design/rc5d_fsm.sv
design/rc5_ir_frame_decoder_unit.sv
verif/tb_top.sv
